// ----- src/ssa_pkg.sv -----
// shared types and constants for the sorted sparse accumulator
// used by ssa_ctrl, ssa_dp and sorted_sparse_accumulator_core; no dependencies
package ssa_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 6;
    localparam int ENTRY_W  = KEY_W + VAL_W;
    localparam int IN_DW    = 64;
    localparam int IN_UW    = 2;
    localparam int OUT_DW   = 72;
    localparam int OUT_UW   = 4;

    // request actions
    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DUMP = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SUMMED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_ZEROED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STAT_W-1:0] ST_DUMP     = 3'd6;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic srch_step;
        logic decide;
        logic shift_step;
        logic wr_new;
        logic emit_res;
        logic dump_emit;
    } ssa_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             cnt_zero;
        logic             srch_done;
        logic             shift_done;
        logic             ins;
        logic             out_free;
        logic             dump_last;
    } ssa_stat_t;

endpackage

// ----- src/ssa_ctrl.sv -----
// controller state machine for the sorted sparse accumulator
// depends on ssa_pkg for the command and status structs
module ssa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssa_pkg::ssa_stat_t stat,
    output ssa_pkg::ssa_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_WRNEW    = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;
    localparam logic [2:0] S_DUMP     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                if (stat.act == ssa_pkg::ACT_NOP)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.act == ssa_pkg::ACT_DUMP)
                begin
                    state_next = stat.cnt_zero ? S_EMIT : S_DUMP;
                end
                else
                begin
                    state_next = stat.cnt_zero ? S_DECIDE : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.srch_step = 1'b1;
                if (stat.srch_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = stat.ins ? S_WRNEW : S_EMIT;
                end
            end
            S_WRNEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_res = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                cmd.dump_emit = 1'b1;
                if (stat.out_free && stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ssa_dp.sv -----
// datapath of the sorted sparse accumulator: entry memory, scan and shift
// pointers, result and output registers; depends on ssa_pkg
module ssa_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssa_pkg::ssa_cmd_t                   cmd,
    output ssa_pkg::ssa_stat_t                  stat,
    input  logic [ssa_pkg::ACT_W-1:0]           in_action,
    input  logic signed [ssa_pkg::KEY_W-1:0]    in_key,
    input  logic signed [ssa_pkg::VAL_W-1:0]    in_amount,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [ssa_pkg::STAT_W-1:0]          out_status,
    output logic signed [ssa_pkg::KEY_W-1:0]    out_key,
    output logic signed [ssa_pkg::VAL_W-1:0]    out_value,
    output logic                                out_entry_valid,
    output logic [ssa_pkg::OCC_W-1:0]           out_occupancy,
    output logic                                out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // entries: key in the low half, value in the high half
    logic [ssa_pkg::ENTRY_W-1:0] mem [CAPACITY];

    logic                             rd_en;
    logic [CW-1:0]                    rd_addr;
    logic [ssa_pkg::ENTRY_W-1:0]      rd_q;
    logic                             wr_en;
    logic [CW-1:0]                    wr_addr;
    logic [ssa_pkg::ENTRY_W-1:0]      wr_data;

    logic [ssa_pkg::ACT_W-1:0]        act_reg;
    logic signed [ssa_pkg::KEY_W-1:0] key_reg;
    logic signed [ssa_pkg::VAL_W-1:0] amt_reg;
    logic [CW-1:0]                    cnt_reg;
    logic [CW-1:0]                    ptr_reg;
    logic [CW-1:0]                    pos_reg;
    logic                             hit_reg;
    logic signed [ssa_pkg::VAL_W-1:0] val_reg;
    logic [CW-1:0]                    src_reg;
    logic [CW-1:0]                    dst_reg;
    logic [CW-1:0]                    mv_reg;
    logic                             pend_reg;
    logic                             ins_reg;
    logic [ssa_pkg::STAT_W-1:0]       res_status_reg;
    logic signed [ssa_pkg::KEY_W-1:0] res_key_reg;
    logic signed [ssa_pkg::VAL_W-1:0] res_val_reg;
    logic                             res_valid_reg;

    logic                             out_valid_reg;
    logic [ssa_pkg::STAT_W-1:0]       out_status_reg;
    logic signed [ssa_pkg::KEY_W-1:0] out_key_reg;
    logic signed [ssa_pkg::VAL_W-1:0] out_value_reg;
    logic                             out_ev_reg;
    logic [ssa_pkg::OCC_W-1:0]        out_occ_reg;
    logic                             out_last_reg;

    logic signed [ssa_pkg::KEY_W-1:0] rkey;
    logic signed [ssa_pkg::VAL_W-1:0] rval;
    logic signed [ssa_pkg::VAL_W-1:0] sum;
    logic [CW-1:0]                    ptr_inc;
    logic                             scan_ge;
    logic                             scan_last;
    logic                             out_free;
    logic                             full;

    assign rkey      = rd_q[ssa_pkg::KEY_W-1:0];
    assign rval      = rd_q[ssa_pkg::ENTRY_W-1:ssa_pkg::KEY_W];
    assign sum       = val_reg + amt_reg;
    assign ptr_inc   = ptr_reg + CW'(1);
    assign scan_ge   = (rkey >= key_reg);
    assign scan_last = (ptr_inc == cnt_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (cnt_reg >= CW'(CAPACITY));

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q <= mem[rd_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = {sum, key_reg};
        if (cmd.dispatch)
        begin
            rd_en = (act_reg != ssa_pkg::ACT_NOP) && (cnt_reg != '0);
        end
        if (cmd.srch_step && !scan_ge && !scan_last)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
        end
        if (cmd.dump_emit && out_free && !scan_last)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
        end
        if (cmd.shift_step)
        begin
            rd_en   = (mv_reg != '0);
            rd_addr = src_reg;
            wr_en   = pend_reg;
            wr_addr = dst_reg;
            wr_data = rd_q;
        end
        if (cmd.decide)
        begin
            // in-place update of a nonzero sum
            wr_en = (act_reg == ssa_pkg::ACT_ADD) && hit_reg && (sum != '0);
        end
        if (cmd.wr_new)
        begin
            wr_en   = 1'b1;
            wr_data = {amt_reg, key_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            mv_reg   <= '0;
            ins_reg  <= 1'b0;
            act_reg  <= ssa_pkg::ACT_NOP;
        end
        else
        begin
            if (cmd.capture)
            begin
                act_reg <= in_action;
            end
            if (cmd.decide)
            begin
                pend_reg <= 1'b0;
                mv_reg   <= '0;
                ins_reg  <= 1'b0;
                if (hit_reg && (act_reg == ssa_pkg::ACT_DEL || sum == '0))
                begin
                    // remove at pos: pull later entries down by one
                    cnt_reg <= cnt_reg - CW'(1);
                    mv_reg  <= cnt_reg - CW'(1) - pos_reg;
                end
                else if (act_reg == ssa_pkg::ACT_ADD && !hit_reg && amt_reg != '0 && !full)
                begin
                    // insert at pos: push entries from pos up by one
                    cnt_reg <= cnt_reg + CW'(1);
                    mv_reg  <= cnt_reg - pos_reg;
                    ins_reg <= 1'b1;
                end
            end
            if (cmd.shift_step)
            begin
                if (mv_reg != '0)
                begin
                    mv_reg <= mv_reg - CW'(1);
                end
                pend_reg <= (mv_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= in_key;
            amt_reg <= in_amount;
        end
        if (cmd.dispatch)
        begin
            ptr_reg        <= '0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            res_status_reg <= ssa_pkg::ST_DUMP;
            res_key_reg    <= '0;
            res_val_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        if (cmd.srch_step)
        begin
            if (scan_ge)
            begin
                pos_reg <= ptr_reg;
                hit_reg <= (rkey == key_reg);
                val_reg <= rval;
            end
            else if (scan_last)
            begin
                pos_reg <= cnt_reg;
                hit_reg <= 1'b0;
            end
            else
            begin
                ptr_reg <= ptr_inc;
            end
        end
        if (cmd.dump_emit && out_free)
        begin
            ptr_reg <= ptr_inc;
        end
        if (cmd.decide)
        begin
            res_key_reg <= key_reg;
            res_val_reg <= '0;
            res_valid_reg <= 1'b0;
            if (act_reg == ssa_pkg::ACT_DEL)
            begin
                if (hit_reg)
                begin
                    res_status_reg <= ssa_pkg::ST_DELETED;
                    res_val_reg    <= val_reg;
                    res_valid_reg  <= 1'b1;
                end
                else
                begin
                    res_status_reg <= ssa_pkg::ST_NOTFOUND;
                end
            end
            else if (hit_reg)
            begin
                if (sum == '0)
                begin
                    res_status_reg <= ssa_pkg::ST_ZEROED;
                end
                else
                begin
                    res_status_reg <= ssa_pkg::ST_SUMMED;
                    res_val_reg    <= sum;
                    res_valid_reg  <= 1'b1;
                end
            end
            else if (amt_reg == '0)
            begin
                res_status_reg <= ssa_pkg::ST_ZEROED;
            end
            else if (full)
            begin
                res_status_reg <= ssa_pkg::ST_FULL;
            end
            else
            begin
                res_status_reg <= ssa_pkg::ST_INSERTED;
                res_val_reg    <= amt_reg;
                res_valid_reg  <= 1'b1;
            end
            if (hit_reg && (act_reg == ssa_pkg::ACT_DEL || sum == '0))
            begin
                src_reg <= pos_reg + CW'(1);
                dst_reg <= pos_reg;
            end
            else
            begin
                src_reg <= cnt_reg - CW'(1);
                dst_reg <= cnt_reg;
            end
        end
        if (cmd.shift_step)
        begin
            if (mv_reg != '0)
            begin
                src_reg <= ins_reg ? (src_reg - CW'(1)) : (src_reg + CW'(1));
            end
            if (pend_reg)
            begin
                dst_reg <= ins_reg ? (dst_reg - CW'(1)) : (dst_reg + CW'(1));
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.emit_res || cmd.dump_emit) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_res && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_value_reg  <= res_val_reg;
            out_ev_reg     <= res_valid_reg;
            out_occ_reg    <= ssa_pkg::OCC_W'(cnt_reg);
            out_last_reg   <= 1'b1;
        end
        else if (cmd.dump_emit && out_free)
        begin
            out_status_reg <= ssa_pkg::ST_DUMP;
            out_key_reg    <= rkey;
            out_value_reg  <= rval;
            out_ev_reg     <= 1'b1;
            out_occ_reg    <= ssa_pkg::OCC_W'(cnt_reg);
            out_last_reg   <= scan_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_key         = out_key_reg;
    assign out_value       = out_value_reg;
    assign out_entry_valid = out_ev_reg;
    assign out_occupancy   = out_occ_reg;
    assign out_last        = out_last_reg;

    assign stat.act        = act_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.srch_done  = scan_ge || scan_last;
    assign stat.shift_done = (mv_reg == '0) && !pend_reg;
    assign stat.ins        = ins_reg;
    assign stat.out_free   = out_free;
    assign stat.dump_last  = scan_last;

endmodule

// ----- src/sorted_sparse_accumulator_core.sv -----
// sorted sparse accumulator: a sparse vector of (key, value) entries kept in
// ascending signed key order, updated by add and delete requests and read out
// by dump requests.
// channels: s_axis takes one request (action in tuser, key and amount in
// tdata); m_axis gives results (status and entry flag in tuser, key, value
// and occupancy in tdata, tlast on the final result of a request).
// one request is worked on at a time; s_axis_tready is high only when idle.
// add/delete: a dispatch step, a linear scan that stops at the entry's place
// (one memory read per cycle), a decide step, a shift of the entries above
// that place through the entry memory's read and write ports, a write of the
// new entry for an insert and a load of the output register.
// dump: the first entry is read in the dispatch step and loaded into the output
// register in the dump step, then one entry per cycle while m_axis_tready is high.
// the next request is taken the cycle after the last result is loaded.
// a stalled receiver holds the output register and the block waits on it.
// reset empties the table at once; the entry memory needs no clearing.
// depends on ssa_pkg, ssa_ctrl and ssa_dp
module sorted_sparse_accumulator_core #(
    parameter int CAPACITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ssa_pkg::IN_DW-1:0]   s_axis_tdata,   // key, amount
    input  logic [ssa_pkg::IN_UW-1:0]   s_axis_tuser,   // action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ssa_pkg::OUT_DW-1:0]  m_axis_tdata,   // entry_key, entry_value, occupancy
    output logic [ssa_pkg::OUT_UW-1:0]  m_axis_tuser,   // status, entry_valid
    output logic                        m_axis_tlast
);

    ssa_pkg::ssa_cmd_t  cmd;
    ssa_pkg::ssa_stat_t stat;

    logic [ssa_pkg::STAT_W-1:0]       out_status;
    logic signed [ssa_pkg::KEY_W-1:0] out_key;
    logic signed [ssa_pkg::VAL_W-1:0] out_value;
    logic                             out_entry_valid;
    logic [ssa_pkg::OCC_W-1:0]        out_occupancy;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssa_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (s_axis_tuser[ssa_pkg::ACT_W-1:0]),
        .in_key          (s_axis_tdata[31:0]),
        .in_amount       (s_axis_tdata[63:32]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_status      (out_status),
        .out_key         (out_key),
        .out_value       (out_value),
        .out_entry_valid (out_entry_valid),
        .out_occupancy   (out_occupancy),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_occupancy, out_value, out_key};
    assign m_axis_tuser = {out_entry_valid, out_status};

endmodule

// ----- tb/sv/tb_sorted_sparse_accumulator_core.sv -----
// testbench for sorted_sparse_accumulator_core: directed and random add, delete
// and dump requests, checked against a scoreboard that keeps its own sorted table
// depends on ssa_pkg and sorted_sparse_accumulator_core
`timescale 1ns / 1ps

module tb_sorted_sparse_accumulator_core;

    localparam int CAPACITY    = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        logic [ssa_pkg::STAT_W-1:0] status;
        logic [ssa_pkg::KEY_W-1:0]  entry_key;
        logic [ssa_pkg::VAL_W-1:0]  entry_value;
        logic                       entry_valid;
        logic [ssa_pkg::OCC_W-1:0]  occupancy;
        logic                       last;
    } ssa_result_t;

    // keeps the expected sorted table and the results still owed by the block
    class ssa_scoreboard;
        logic [ssa_pkg::KEY_W-1:0] slot_keys [CAPACITY];
        logic [ssa_pkg::VAL_W-1:0] slot_values [CAPACITY];
        int                        count;
        int                        errors;
        ssa_result_t               owed_q [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push(logic [ssa_pkg::STAT_W-1:0] st, logic [ssa_pkg::KEY_W-1:0] k,
                           logic [ssa_pkg::VAL_W-1:0] v, logic vld, logic lst);
            ssa_result_t r;
            r.status      = st;
            r.entry_key   = k;
            r.entry_value = v;
            r.entry_valid = vld;
            r.occupancy   = ssa_pkg::OCC_W'(count);
            r.last        = lst;
            owed_q.push_back(r);
        endfunction

        function void remove_slot(int pos);
            int i;
            for (i = pos; i + 1 < count; i++)
            begin
                slot_keys[i]   = slot_keys[i + 1];
                slot_values[i] = slot_values[i + 1];
            end
            count--;
        endfunction

        function bit lookup(logic [ssa_pkg::KEY_W-1:0] k,
                            output logic [ssa_pkg::VAL_W-1:0] v);
            int i;
            v = '0;
            for (i = 0; i < count; i++)
            begin
                if (slot_keys[i] == k)
                begin
                    v = slot_values[i];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic [ssa_pkg::ACT_W-1:0] act,
                                   logic [ssa_pkg::KEY_W-1:0] k,
                                   logic [ssa_pkg::VAL_W-1:0] amt);
            int                        pos;
            int                        i;
            bit                        hit;
            logic [ssa_pkg::VAL_W-1:0] sum;
            if (act == ssa_pkg::ACT_NOP)
                return;
            if (act == ssa_pkg::ACT_DUMP)
            begin
                if (count == 0)
                    push(ssa_pkg::ST_DUMP, '0, '0, 1'b0, 1'b1);
                for (i = 0; i < count; i++)
                    push(ssa_pkg::ST_DUMP, slot_keys[i], slot_values[i], 1'b1,
                         i == count - 1);
                return;
            end
            pos = 0;
            while (pos < count && $signed(slot_keys[pos]) < $signed(k))
                pos++;
            hit = pos < count && slot_keys[pos] == k;
            if (act == ssa_pkg::ACT_DEL)
            begin
                if (hit)
                begin
                    sum = slot_values[pos];
                    remove_slot(pos);
                    push(ssa_pkg::ST_DELETED, k, sum, 1'b1, 1'b1);
                end
                else
                    push(ssa_pkg::ST_NOTFOUND, k, '0, 1'b0, 1'b1);
            end
            else if (hit)
            begin
                sum = slot_values[pos] + amt;
                if (sum == '0)
                begin
                    remove_slot(pos);
                    push(ssa_pkg::ST_ZEROED, k, '0, 1'b0, 1'b1);
                end
                else
                begin
                    slot_values[pos] = sum;
                    push(ssa_pkg::ST_SUMMED, k, sum, 1'b1, 1'b1);
                end
            end
            else if (amt == '0)
                push(ssa_pkg::ST_ZEROED, k, '0, 1'b0, 1'b1);
            else if (count >= CAPACITY)
                push(ssa_pkg::ST_FULL, k, '0, 1'b0, 1'b1);
            else
            begin
                for (i = count; i > pos; i--)
                begin
                    slot_keys[i]   = slot_keys[i - 1];
                    slot_values[i] = slot_values[i - 1];
                end
                slot_keys[pos]   = k;
                slot_values[pos] = amt;
                count++;
                push(ssa_pkg::ST_INSERTED, k, amt, 1'b1, 1'b1);
            end
        endfunction

        function void check_result(ssa_result_t got);
            ssa_result_t exp;
            if (owed_q.size() == 0)
            begin
                $error("result with nothing owed: status %0d key %h", got.status,
                       got.entry_key);
                errors++;
                return;
            end
            exp = owed_q.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.entry_key !== exp.entry_key)
            begin
                $error("entry_key: expected %h, got %h", exp.entry_key, got.entry_key);
                errors++;
            end
            if (got.entry_value !== exp.entry_value)
            begin
                $error("entry_value: expected %h, got %h", exp.entry_value, got.entry_value);
                errors++;
            end
            if (got.entry_valid !== exp.entry_valid)
            begin
                $error("entry_valid: expected %0d, got %0d", exp.entry_valid, got.entry_valid);
                errors++;
            end
            if (got.occupancy !== exp.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [ssa_pkg::IN_DW-1:0]   s_axis_tdata = '0;     // key, amount
    logic [ssa_pkg::IN_UW-1:0]   s_axis_tuser = '0;     // action
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [ssa_pkg::OUT_DW-1:0]  m_axis_tdata;          // entry_key, entry_value, occupancy
    logic [ssa_pkg::OUT_UW-1:0]  m_axis_tuser;          // status, entry_valid
    logic                        m_axis_tlast;

    ssa_scoreboard               sb;
    int                          cycle_count = 0;
    int                          burst_left = 0;
    int                          stall_left = 0;
    int                          rx_mode = 0;
    int                          rx_mode_left = 0;
    logic [ssa_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];

    sorted_sparse_accumulator_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sorted_sparse_accumulator_core NOT OK");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        ssa_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status      = m_axis_tuser[ssa_pkg::STAT_W-1:0];
            got.entry_valid = m_axis_tuser[ssa_pkg::STAT_W];
            got.entry_key   = m_axis_tdata[ssa_pkg::KEY_W-1:0];
            got.entry_value = m_axis_tdata[ssa_pkg::KEY_W +: ssa_pkg::VAL_W];
            got.occupancy   = m_axis_tdata[ssa_pkg::ENTRY_W +: ssa_pkg::OCC_W];
            got.last        = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // receiver: modes of always ready, coin flips and long stalls
    always @(negedge clk)
    begin : rx_pattern
        bit rdy;
        if (rx_mode_left == 0)
        begin
            rx_mode      = int'($urandom_range(0, 2));
            rx_mode_left = int'($urandom_range(20, 120));
        end
        rx_mode_left = rx_mode_left - 1;
        rdy = 1'b1;
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            rdy = 1'b0;
        end
        else if (rx_mode == 1)
            rdy = 1'($urandom_range(0, 1));
        else if (rx_mode == 2 && $urandom_range(0, 7) == 0)
        begin
            stall_left = int'($urandom_range(1, 10));
            rdy = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    task automatic send_request(input logic [ssa_pkg::ACT_W-1:0] act,
                                input logic [ssa_pkg::KEY_W-1:0] k,
                                input logic [ssa_pkg::VAL_W-1:0] amt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
                                                     : int'($urandom_range(1, 8));
            gap = int'($urandom_range(0, 6));
            if (gap != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {amt, k};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(act, k, amt);
        burst_left = burst_left - 1;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ssa_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [ssa_pkg::VAL_W-1:0] pick_amount(
        logic [ssa_pkg::KEY_W-1:0] k);
        logic [ssa_pkg::VAL_W-1:0] cur;
        bit                        found;
        int                        sel;
        sel   = int'($urandom_range(0, 99));
        found = sb.lookup(k, cur);
        if (sel < 15 && found)
            return -cur;    // cancels the stored value
        if (sel < 50)
            return ssa_pkg::VAL_W'($urandom_range(0, 200)) - ssa_pkg::VAL_W'(100);
        if (sel < 56)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0001;
                default: return 32'hffff_ffff;
            endcase
        end
        if (sel < 60)
            return '0;
        return $urandom;
    endfunction

    task automatic random_request();
        int                        sel;
        logic [ssa_pkg::KEY_W-1:0] k;
        sel = int'($urandom_range(0, 99));
        k   = pick_key();
        if (sel < 60)
            send_request(ssa_pkg::ACT_ADD, k, pick_amount(k));
        else if (sel < 80)
            send_request(ssa_pkg::ACT_DEL, k, $urandom);
        else if (sel < 95)
            send_request(ssa_pkg::ACT_DUMP, $urandom, $urandom);
        else
            send_request(ssa_pkg::ACT_NOP, $urandom, $urandom);
    endtask

    initial
    begin : stimulus
        int                        i;
        logic [ssa_pkg::KEY_W-1:0] k;
        logic [ssa_pkg::VAL_W-1:0] cur;
        sb = new();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (i = 4; i < POOL_SIZE; i++)
            key_pool[i] = (i < 14) ? ssa_pkg::KEY_W'($urandom_range(0, 40)) -
                                     ssa_pkg::KEY_W'(20) : $urandom;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty dump, absent keys, extreme keys and amounts, wrap to zero
        send_request(ssa_pkg::ACT_DUMP, 32'hffff_ffff, 32'hffff_ffff);
        send_request(ssa_pkg::ACT_DEL, 32'd5, 32'd0);
        send_request(ssa_pkg::ACT_ADD, 32'd5, 32'd0);
        send_request(ssa_pkg::ACT_ADD, 32'h8000_0000, 32'h7fff_ffff);
        send_request(ssa_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_request(ssa_pkg::ACT_ADD, 32'd100, 32'd7);
        send_request(ssa_pkg::ACT_ADD, -32'sd100, 32'd9);
        send_request(ssa_pkg::ACT_ADD, 32'd0, 32'd1);
        send_request(ssa_pkg::ACT_ADD, 32'hffff_ffff, 32'hffff_ffff);
        send_request(ssa_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_request(ssa_pkg::ACT_ADD, 32'h8000_0000, 32'd1);
        send_request(ssa_pkg::ACT_ADD, 32'd0, 32'd0);
        send_request(ssa_pkg::ACT_ADD, 32'd0, 32'hffff_ffff);
        send_request(ssa_pkg::ACT_DUMP, 32'd0, 32'd0);
        send_request(ssa_pkg::ACT_DEL, 32'hffff_ffff, 32'd0);
        send_request(ssa_pkg::ACT_DEL, 32'hffff_ffff, 32'd0);
        send_request(ssa_pkg::ACT_NOP, 32'hffff_ffff, 32'hffff_ffff);
        send_request(ssa_pkg::ACT_DEL, 32'h8000_0000, 32'd0);
        send_request(ssa_pkg::ACT_DEL, 32'd100, 32'd0);
        send_request(ssa_pkg::ACT_DEL, -32'sd100, 32'd0);
        send_request(ssa_pkg::ACT_DUMP, 32'd0, 32'd0);

        for (i = 0; i < 70; i++)
            random_request();

        // hold off until the block has delivered everything, then fill the table
        wait_drained();
        for (i = 0; i < 36; i++)
            send_request(ssa_pkg::ACT_ADD, $urandom, $urandom | 32'd1);
        send_request(ssa_pkg::ACT_DUMP, $urandom, $urandom);
        for (i = 0; i < 4; i++)
        begin
            k = sb.slot_keys[$urandom_range(0, sb.count - 1)];
            if (sb.lookup(k, cur))
                send_request(ssa_pkg::ACT_ADD, k, ssa_pkg::VAL_W'($urandom_range(1, 50)));
        end
        k = sb.slot_keys[$urandom_range(0, sb.count - 1)];
        send_request(ssa_pkg::ACT_DEL, k, $urandom);
        send_request(ssa_pkg::ACT_ADD, $urandom, $urandom | 32'd1);
        send_request(ssa_pkg::ACT_ADD, $urandom, $urandom | 32'd1);
        send_request(ssa_pkg::ACT_DUMP, $urandom, $urandom);

        for (i = 0; i < 75; i++)
            random_request();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_sorted_sparse_accumulator_core OK");
        else
            $display("tb_sorted_sparse_accumulator_core NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ssa_pkg.sv
src/ssa_ctrl.sv
src/ssa_dp.sv
src/sorted_sparse_accumulator_core.sv
tb/sv/tb_sorted_sparse_accumulator_core.sv
